// ===== sv/nie_pkg.sv =====
// Shared types and constants of the nibble index / escape encoder.
package nie_pkg;

    localparam int ADDR_W      = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_ENCODE = 2'd1;
    localparam logic [1:0] MODE_FLUSH  = 2'd2;

    localparam logic [3:0] ESCAPE_NIBBLE = 4'hf;

    localparam logic REG_ENTRIES   = 1'b0;
    localparam logic REG_RAW_WIDTH = 1'b1;

    localparam logic [3:0] ENTRIES_RESET   = 4'd15;
    localparam logic [2:0] RAW_WIDTH_RESET = 3'd4;

    typedef struct packed {
        logic [3:0] entries_in_use;
        logic [2:0] raw_width_bytes;
    } cfg_t;

    // One result-producing item as handed from front to back.
    typedef struct packed {
        logic [7:0]  first_byte;
        logic        first_valid;
        logic        overflow;
        logic [2:0]  raw_count;
        logic [31:0] raw_value;
        logic [31:0] indexed_total;
        logic [31:0] escape_total;
    } cmd_t;

endpackage

// ===== sv/nie_if.sv =====
// Valid/ready channel interfaces for input items and result items.
interface nie_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [3:0]  entry_index;
    logic [31:0] value;

    modport source (output valid, output mode, output entry_index, output value, input ready);
    modport sink (input valid, input mode, input entry_index, input value, output ready);
endinterface

interface nie_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        byte_valid;
    logic        last_of_run;
    logic        overflow_error;
    logic [31:0] indexed_total;
    logic [31:0] escape_total;

    modport source (
        output valid, output data_byte, output byte_valid, output last_of_run,
        output overflow_error, output indexed_total, output escape_total,
        input ready
    );
    modport sink (
        input valid, input data_byte, input byte_valid, input last_of_run,
        input overflow_error, input indexed_total, input escape_total,
        output ready
    );
endinterface

// ===== sv/nie_regs.sv =====
// APB configuration registers: search count and raw byte width.
module nie_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [nie_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output nie_pkg::cfg_t              cfg
);

    logic [3:0] entries_reg;
    logic [3:0] entries_next;
    logic [2:0] raw_width_reg;
    logic [2:0] raw_width_next;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb
    begin
        entries_next   = entries_reg;
        raw_width_next = raw_width_reg;
        if (wr_en)
        begin
            case (paddr[2])
                nie_pkg::REG_ENTRIES:   entries_next   = pwdata[3:0];
                nie_pkg::REG_RAW_WIDTH: raw_width_next = pwdata[2:0];
                default:                entries_next   = entries_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            nie_pkg::REG_ENTRIES:   prdata = {28'd0, entries_reg};
            nie_pkg::REG_RAW_WIDTH: prdata = {29'd0, raw_width_reg};
            default:                prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_reg   <= nie_pkg::ENTRIES_RESET;
            raw_width_reg <= nie_pkg::RAW_WIDTH_RESET;
        end
        else
        begin
            entries_reg   <= entries_next;
            raw_width_reg <= raw_width_next;
        end
    end

    assign cfg.entries_in_use  = entries_reg;
    assign cfg.raw_width_bytes = raw_width_reg;

endmodule

// ===== sv/nie_front.sv =====
// Front end: accepts items, searches the table, packs nibbles, keeps counters.
module nie_front #(
    parameter int TABLE_DEPTH = 15
) (
    input  logic          clk,
    input  logic          rst_n,
    nie_in_if.sink        din,
    input  nie_pkg::cfg_t cfg,
    input  logic          full,
    output logic          push,
    output nie_pkg::cmd_t cmd
);

    logic [31:0] table_reg [TABLE_DEPTH];
    logic        half_pending_reg;
    logic        half_pending_next;
    logic [3:0]  pending_low_reg;
    logic [3:0]  pending_low_next;
    logic [31:0] indexed_cnt_reg;
    logic [31:0] indexed_cnt_next;
    logic [31:0] escape_cnt_reg;
    logic [31:0] escape_cnt_next;

    logic        accept;
    logic        hit_found;
    logic [3:0]  hit_idx;
    logic [2:0]  width_eff;
    logic        too_big;
    logic [31:0] indexed_inc;
    logic [31:0] escape_inc;

    assign din.ready = !full;
    assign accept    = din.valid && din.ready;

    // Lowest matching slot among the searched entries wins.
    always_comb
    begin
        hit_found = 1'b0;
        hit_idx   = 4'd0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--)
        begin
            if ((4'(i) < cfg.entries_in_use) && (table_reg[i] == din.value))
            begin
                hit_found = 1'b1;
                hit_idx   = 4'(i);
            end
        end
    end

    always_comb
    begin
        case (cfg.raw_width_bytes)
            3'd0:    width_eff = 3'd1;
            3'd1:    width_eff = 3'd1;
            3'd2:    width_eff = 3'd2;
            3'd3:    width_eff = 3'd3;
            default: width_eff = 3'd4;
        endcase
    end

    always_comb
    begin
        case (width_eff)
            3'd1:    too_big = |din.value[31:8];
            3'd2:    too_big = |din.value[31:16];
            3'd3:    too_big = |din.value[31:24];
            default: too_big = 1'b0;
        endcase
    end

    assign indexed_inc = (&indexed_cnt_reg) ? indexed_cnt_reg : indexed_cnt_reg + 32'd1;
    assign escape_inc  = (&escape_cnt_reg) ? escape_cnt_reg : escape_cnt_reg + 32'd1;

    always_comb
    begin
        half_pending_next = half_pending_reg;
        pending_low_next  = pending_low_reg;
        indexed_cnt_next  = indexed_cnt_reg;
        escape_cnt_next   = escape_cnt_reg;
        push              = 1'b0;
        cmd.first_byte    = 8'd0;
        cmd.first_valid   = 1'b0;
        cmd.overflow      = 1'b0;
        cmd.raw_count     = 3'd0;
        cmd.raw_value     = din.value;
        cmd.indexed_total = indexed_cnt_reg;
        cmd.escape_total  = escape_cnt_reg;
        if (accept)
        begin
            case (din.mode)
                nie_pkg::MODE_ENCODE:
                begin
                    if (hit_found)
                    begin
                        indexed_cnt_next = indexed_inc;
                        if (!half_pending_reg)
                        begin
                            half_pending_next = 1'b1;
                            pending_low_next  = hit_idx;
                        end
                        else
                        begin
                            half_pending_next = 1'b0;
                            push              = 1'b1;
                            cmd.first_byte    = {hit_idx, pending_low_reg};
                            cmd.first_valid   = 1'b1;
                            cmd.indexed_total = indexed_inc;
                        end
                    end
                    else if (too_big)
                    begin
                        // Drop the delta, report only.
                        push         = 1'b1;
                        cmd.overflow = 1'b1;
                    end
                    else
                    begin
                        escape_cnt_next   = escape_inc;
                        half_pending_next = 1'b0;
                        pending_low_next  = 4'd0;
                        push              = 1'b1;
                        cmd.first_byte    = half_pending_reg ?
                                            {nie_pkg::ESCAPE_NIBBLE, pending_low_reg} :
                                            {4'd0, nie_pkg::ESCAPE_NIBBLE};
                        cmd.first_valid   = 1'b1;
                        cmd.raw_count     = width_eff;
                        cmd.escape_total  = escape_inc;
                    end
                end
                nie_pkg::MODE_FLUSH:
                begin
                    half_pending_next = 1'b0;
                    pending_low_next  = 4'd0;
                    indexed_cnt_next  = 32'd0;
                    escape_cnt_next   = 32'd0;
                    push              = 1'b1;
                    cmd.first_byte    = half_pending_reg ? {4'd0, pending_low_reg} : 8'd0;
                    cmd.first_valid   = half_pending_reg;
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (din.mode == nie_pkg::MODE_LOAD))
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                if (din.entry_index == 4'(i))
                begin
                    table_reg[i] <= din.value;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_pending_reg <= 1'b0;
            pending_low_reg  <= 4'd0;
            indexed_cnt_reg  <= 32'd0;
            escape_cnt_reg   <= 32'd0;
        end
        else
        begin
            half_pending_reg <= half_pending_next;
            pending_low_reg  <= pending_low_next;
            indexed_cnt_reg  <= indexed_cnt_next;
            escape_cnt_reg   <= escape_cnt_next;
        end
    end

endmodule

// ===== sv/nie_fifo.sv =====
// Short command queue between front and back.
module nie_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  nie_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output nie_pkg::cmd_t head_cmd
);

    localparam int CNT_W = nie_pkg::QPTR_W + 1;

    nie_pkg::cmd_t               slot_reg [nie_pkg::QUEUE_DEPTH];
    logic [nie_pkg::QPTR_W-1:0]  wr_ptr_reg;
    logic [nie_pkg::QPTR_W-1:0]  wr_ptr_next;
    logic [nie_pkg::QPTR_W-1:0]  rd_ptr_reg;
    logic [nie_pkg::QPTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]            count_reg;
    logic [CNT_W-1:0]            count_next;
    logic                        do_push;
    logic                        do_pop;

    assign full       = (count_reg == CNT_W'(nie_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== sv/nie_back.sv =====
// Back end: expands each command into its result items through an output register.
module nie_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          head_valid,
    input  nie_pkg::cmd_t head_cmd,
    output logic          pop,
    nie_out_if.source     dout
);

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [7:0]  data_byte_reg;
    logic [7:0]  data_byte_next;
    logic        byte_valid_reg;
    logic        byte_valid_next;
    logic        last_reg;
    logic        last_next;
    logic        overflow_reg;
    logic        overflow_next;
    logic [31:0] indexed_reg;
    logic [31:0] indexed_next;
    logic [31:0] escape_reg;
    logic [31:0] escape_next;
    logic [2:0]  beat_reg;
    logic [2:0]  beat_next;

    logic        load;
    logic        is_last;

    assign load    = head_valid && (!out_valid_reg || dout.ready);
    assign is_last = (beat_reg == head_cmd.raw_count);
    assign pop     = load && is_last;

    always_comb
    begin
        out_valid_next  = out_valid_reg && !dout.ready;
        data_byte_next  = data_byte_reg;
        byte_valid_next = byte_valid_reg;
        last_next       = last_reg;
        overflow_next   = overflow_reg;
        indexed_next    = indexed_reg;
        escape_next     = escape_reg;
        beat_next       = beat_reg;
        if (load)
        begin
            out_valid_next  = 1'b1;
            last_next       = is_last;
            indexed_next    = head_cmd.indexed_total;
            escape_next     = head_cmd.escape_total;
            beat_next       = is_last ? 3'd0 : beat_reg + 3'd1;
            byte_valid_next = 1'b1;
            overflow_next   = 1'b0;
            // Beat zero is the code byte, later beats are raw bytes low first.
            case (beat_reg)
                3'd0:
                begin
                    data_byte_next  = head_cmd.first_byte;
                    byte_valid_next = head_cmd.first_valid;
                    overflow_next   = head_cmd.overflow;
                end
                3'd1:    data_byte_next = head_cmd.raw_value[7:0];
                3'd2:    data_byte_next = head_cmd.raw_value[15:8];
                3'd3:    data_byte_next = head_cmd.raw_value[23:16];
                default: data_byte_next = head_cmd.raw_value[31:24];
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        data_byte_reg  <= data_byte_next;
        byte_valid_reg <= byte_valid_next;
        last_reg       <= last_next;
        overflow_reg   <= overflow_next;
        indexed_reg    <= indexed_next;
        escape_reg     <= escape_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            beat_reg      <= 3'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            beat_reg      <= beat_next;
        end
    end

    assign dout.valid          = out_valid_reg;
    assign dout.data_byte      = data_byte_reg;
    assign dout.byte_valid     = byte_valid_reg;
    assign dout.last_of_run    = last_reg;
    assign dout.overflow_error = overflow_reg;
    assign dout.indexed_total  = indexed_reg;
    assign dout.escape_total   = escape_reg;

endmodule

// ===== sv/nibble_index_escape_encoder.sv =====
// Nibble index / escape encoder top level: front, command queue, back, registers.
// Takes one input item per cycle whenever the four-entry command queue has room. Loads and
// the first half of an index pair produce no result; a completed index byte, an overflow
// report and a flush produce one result; an escape produces a code byte plus raw_width_bytes
// raw bytes (0 read as 1, above 4 as 4), so 2 to 5 results. The back end's output register
// sends one result per cycle while dout.ready holds, so sustained input rate is one item per
// cycle while the results it causes average at most one per cycle; during escape raw bytes
// the queue fills and input stalls. An item's first result passes a queue slot and then
// the output register before it is presented on dout. Table loads take effect for the next item.
module nibble_index_escape_encoder #(
    parameter int TABLE_DEPTH = 15
) (
    input  logic                       clk,
    input  logic                       rst_n,
    nie_in_if.sink                     din,
    nie_out_if.source                  dout,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [nie_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    nie_pkg::cfg_t cfg;
    nie_pkg::cmd_t push_cmd;
    nie_pkg::cmd_t head_cmd;
    logic          push;
    logic          full;
    logic          pop;
    logic          head_valid;

    nie_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    nie_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din),
        .cfg   (cfg),
        .full  (full),
        .push  (push),
        .cmd   (push_cmd)
    );

    nie_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    nie_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .dout       (dout)
    );

endmodule
